// ----- hw/rtl/pgtl_pkg.sv -----
// Package: shared constants, types and pair-index helpers for the tract length block.
package pgtl_pkg;

    localparam int SAMPLE_COUNT = 8;
    localparam int PAIR_SLOTS   = SAMPLE_COUNT * (SAMPLE_COUNT - 1) / 2;
    localparam int SLOT_W       = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
    localparam int POS_W        = 31;
    localparam int GENO_W       = 16;
    localparam int SAMPLE_W     = 3;
    localparam int CODE_W       = 2;

    localparam logic [CODE_W-1:0] GT_HOM_REF = 2'd0;
    localparam logic [CODE_W-1:0] GT_HOM_ALT = 2'd2;

    localparam logic [POS_W-1:0] LONG_TRACT_MIN_RESET = 31'd10000;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] first;
        logic [SAMPLE_W-1:0] second;
    } pair_t;

    // Position store access for one cycle.
    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [POS_W-1:0]  wr_data;
    } store_req_t;

    // Slot of pair (i, j), i < j, in pair order.
    function automatic logic [SLOT_W-1:0] pair_slot(input int i, input int j);
        int s;
        s = ((i * (2 * SAMPLE_COUNT - i - 1)) >> 1) + (j - i - 1);
        return SLOT_W'(s);
    endfunction

    // Sample indexes of a slot: a constant table.
    function automatic pair_t pair_of_slot(input logic [SLOT_W-1:0] slot);
        pair_t p;
        p = '0;
        for (int i = 0; i < SAMPLE_COUNT; i++)
        begin
            for (int j = i + 1; j < SAMPLE_COUNT; j++)
            begin
                if (pair_slot(i, j) == slot)
                begin
                    p.first  = SAMPLE_W'(i);
                    p.second = SAMPLE_W'(j);
                end
            end
        end
        return p;
    endfunction

endpackage

// ----- hw/rtl/pgtl_ifs.sv -----
// Interfaces: site input, result output and configuration write channels.
interface pgtl_site_if;
    logic                          valid;
    logic                          ready;
    logic                          new_scaffold;
    logic                          is_indel;
    logic [pgtl_pkg::POS_W-1:0]    position;
    logic [pgtl_pkg::GENO_W-1:0]   genotypes;

    modport source (output valid, new_scaffold, is_indel, position, genotypes, input ready);
    modport sink   (input valid, new_scaffold, is_indel, position, genotypes, output ready);
endinterface

interface pgtl_result_if;
    logic                          valid;
    logic                          ready;
    logic [pgtl_pkg::SAMPLE_W-1:0] first_sample;
    logic [pgtl_pkg::SAMPLE_W-1:0] second_sample;
    logic [pgtl_pkg::POS_W-1:0]    tract_length;
    logic                          long_tract;
    logic                          last_of_site;

    modport source (output valid, first_sample, second_sample, tract_length, long_tract,
                    last_of_site, input ready);
    modport sink   (input valid, first_sample, second_sample, tract_length, long_tract,
                    last_of_site, output ready);
endinterface

interface pgtl_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [pgtl_pkg::POS_W-1:0] long_tract_min;

    modport source (output valid, long_tract_min, input ready);
    modport sink   (input valid, long_tract_min, output ready);
endinterface

// ----- hw/rtl/pgtl_pos_store.sv -----
// Per-pair last incompatible position store: synchronous memory plus valid bits.
module pgtl_pos_store
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  pgtl_pkg::store_req_t       req,
    output logic [pgtl_pkg::POS_W-1:0] rd_data
);

    logic [pgtl_pkg::POS_W-1:0]    mem [pgtl_pkg::PAIR_SLOTS];
    logic [pgtl_pkg::PAIR_SLOTS-1:0] valid_reg;
    logic [pgtl_pkg::PAIR_SLOTS-1:0] valid_next;
    logic [pgtl_pkg::POS_W-1:0]    rd_data_reg;
    logic                          rd_valid_reg;

    // Clear marks every entry as empty, so it reads as zero; a write marks its entry as holding data.
    always_comb
    begin
        valid_next = valid_reg;
        if (req.clear)
            valid_next = '0;
        else if (req.wr_en)
            valid_next[req.wr_addr] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.rd_en)
                rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.wr_addr] <= req.wr_data;
        if (req.rd_en)
            rd_data_reg <= mem[req.rd_addr];
    end

    // An entry never written since the last clear reads as zero.
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- hw/rtl/pairwise_genotype_tract_lengths.sv -----
// Top level: pairwise genotype tract lengths over per-pair position memory.
//
// Usage:
//   site   - input channel, one word per variant site (new_scaffold, is_indel,
//            position, genotypes with 2 bits per sample).
//   result - output channel, one word per incompatible sample pair of a site,
//            in pair order (0,1), (0,2), ... ; last_of_site marks the final one.
//   cfg    - write channel for long_tract_min; always ready, write it only
//            while the block is idle.
// Timing: the scan issues one pair per cycle while result is not stalled, with one
//   read and one write port on the position memory. After a site is accepted,
//   each pair passes the scan stage, the memory stage and the output register.
//   The next site is taken only once the scan has ended and its last read
//   has left the memory stage. An indel or a site with no incompatible pair
//   never enters the scan.
// Reset: all stored positions read as zero (valid bits clear at once, no
//   sweep), long_tract_min returns to 10000, no word is pending.
// Stall: when result is not ready, the output register holds its word and
//   the scan stops in place; no word is lost or repeated.
module pairwise_genotype_tract_lengths
(
    input  logic          clk,
    input  logic          rst_n,
    pgtl_cfg_if.sink      cfg,
    pgtl_site_if.sink     site,
    pgtl_result_if.source result
);

    // Configuration register
    logic [pgtl_pkg::POS_W-1:0] long_min_reg;

    // Scan stage: remaining incompatible pairs of the current site
    pgtl_pkg::state_t               state_reg, state_next;
    logic [pgtl_pkg::PAIR_SLOTS-1:0] mask_reg, mask_next;
    logic [pgtl_pkg::POS_W-1:0]     pos_reg;

    // Memory stage: one read in flight
    logic                          b_valid_reg, b_valid_next;
    logic [pgtl_pkg::SLOT_W-1:0]   b_slot_reg;
    logic                          b_last_reg;

    // Output register
    logic                          out_valid_reg, out_valid_next;
    logic [pgtl_pkg::SAMPLE_W-1:0] out_first_reg;
    logic [pgtl_pkg::SAMPLE_W-1:0] out_second_reg;
    logic [pgtl_pkg::POS_W-1:0]    out_len_reg;
    logic                          out_long_reg;
    logic                          out_last_reg;

    logic                           site_fire;
    logic [pgtl_pkg::PAIR_SLOTS-1:0] site_mask;
    logic [pgtl_pkg::SLOT_W-1:0]    a_slot;
    logic [pgtl_pkg::PAIR_SLOTS-1:0] mask_rest;
    logic                           a_issue;
    logic                           out_free;
    logic                           b_fire;
    logic [pgtl_pkg::POS_W-1:0]     prev_pos;
    logic [pgtl_pkg::POS_W-1:0]     len;
    pgtl_pkg::pair_t                b_pair;
    pgtl_pkg::store_req_t           store_req;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            long_min_reg <= pgtl_pkg::LONG_TRACT_MIN_RESET;
        else if (cfg.valid)
            long_min_reg <= cfg.long_tract_min;
    end

    // Incompatible pairs of the incoming site: one hom ref, the other hom alt.
    always_comb
    begin
        logic [pgtl_pkg::CODE_W-1:0] ci;
        logic [pgtl_pkg::CODE_W-1:0] cj;
        site_mask = '0;
        for (int i = 0; i < pgtl_pkg::SAMPLE_COUNT; i++)
        begin
            for (int j = i + 1; j < pgtl_pkg::SAMPLE_COUNT; j++)
            begin
                ci = site.genotypes[pgtl_pkg::CODE_W*i +: pgtl_pkg::CODE_W];
                cj = site.genotypes[pgtl_pkg::CODE_W*j +: pgtl_pkg::CODE_W];
                site_mask[pgtl_pkg::pair_slot(i, j)] =
                    (ci == pgtl_pkg::GT_HOM_REF && cj == pgtl_pkg::GT_HOM_ALT) ||
                    (ci == pgtl_pkg::GT_HOM_ALT && cj == pgtl_pkg::GT_HOM_REF);
            end
        end
    end

    // Lowest pending pair of the scan; drop it once issued.
    always_comb
    begin
        a_slot = '0;
        for (int k = pgtl_pkg::PAIR_SLOTS - 1; k >= 0; k--)
        begin
            if (mask_reg[k])
                a_slot = pgtl_pkg::SLOT_W'(k);
        end
    end

    assign mask_rest = mask_reg & (mask_reg - pgtl_pkg::PAIR_SLOTS'(1));

    // Handshake and stage advance
    assign out_free  = !out_valid_reg || result.ready;
    assign b_fire    = b_valid_reg && out_free;
    assign a_issue   = (state_reg == pgtl_pkg::ST_SCAN) && (!b_valid_reg || b_fire);
    assign site.ready = (state_reg == pgtl_pkg::ST_IDLE) && !b_valid_reg;
    assign site_fire = site.valid && site.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pgtl_pkg::ST_IDLE:
            begin
                if (site_fire && !site.is_indel && (site_mask != '0))
                    state_next = pgtl_pkg::ST_SCAN;
            end
            pgtl_pkg::ST_SCAN:
            begin
                if (a_issue && (mask_rest == '0))
                    state_next = pgtl_pkg::ST_IDLE;
            end
            default:
                state_next = pgtl_pkg::ST_IDLE;
        endcase
    end

    // Control outputs of the scan
    always_comb
    begin
        mask_next      = mask_reg;
        b_valid_next   = b_valid_reg;
        out_valid_next = out_valid_reg;
        unique case (state_reg)
            pgtl_pkg::ST_IDLE:
            begin
                if (site_fire && !site.is_indel)
                    mask_next = site_mask;
            end
            pgtl_pkg::ST_SCAN:
            begin
                if (a_issue)
                    mask_next = mask_rest;
            end
            default:
                mask_next = '0;
        endcase
        if (a_issue)
            b_valid_next = 1'b1;
        else if (b_fire)
            b_valid_next = 1'b0;
        if (b_fire)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pgtl_pkg::ST_IDLE;
            mask_reg      <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mask_reg      <= mask_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (site_fire)
            pos_reg <= site.position;
        if (a_issue)
        begin
            b_slot_reg <= a_slot;
            b_last_reg <= (mask_rest == '0);
        end
        if (b_fire)
        begin
            out_first_reg  <= b_pair.first;
            out_second_reg <= b_pair.second;
            out_len_reg    <= len;
            out_long_reg   <= (len >= long_min_reg);
            out_last_reg   <= b_last_reg;
        end
    end

    // Read the stored position at issue, write the new one when the word moves on; a new scaffold clears the store.
    always_comb
    begin
        store_req.clear   = site_fire && site.new_scaffold;
        store_req.rd_en   = a_issue;
        store_req.rd_addr = a_slot;
        store_req.wr_en   = b_fire;
        store_req.wr_addr = b_slot_reg;
        store_req.wr_data = pos_reg;
    end

    pgtl_pos_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_data (prev_pos)
    );

    // Saturate a backward step to zero.
    assign len    = (pos_reg >= prev_pos) ? (pos_reg - prev_pos) : '0;
    assign b_pair = pgtl_pkg::pair_of_slot(b_slot_reg);

    assign result.valid         = out_valid_reg;
    assign result.first_sample  = out_first_reg;
    assign result.second_sample = out_second_reg;
    assign result.tract_length  = out_len_reg;
    assign result.long_tract    = out_long_reg;
    assign result.last_of_site  = out_last_reg;

    // No pending pairs outside a scan.
    a_idle_mask_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pgtl_pkg::ST_IDLE) |-> (mask_reg == '0))
        else $error("pending pairs while idle");

    // The last read of a site ends the scan.
    a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && b_last_reg) |-> (state_reg == pgtl_pkg::ST_IDLE))
        else $error("scan still running after last read");

    // A scaffold clear never meets a pending write.
    a_clear_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(store_req.clear && store_req.wr_en))
        else $error("clear collides with position write");

    // A read issued while a word waits must not overwrite the memory stage.
    a_issue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        a_issue |-> (!b_valid_reg || b_fire))
        else $error("read issued over a stalled memory stage");

endmodule

// ----- tb/pairwise_genotype_tract_lengths_tb.sv -----
// Testbench: site stimulus, result checking against a pair-position predictor, and threshold phases.
module pairwise_genotype_tract_lengths_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pgtl_pkg::*;

    // Genotype codes the package leaves unnamed; a sample with either one
    // never forms an incompatible pair.
    localparam logic [CODE_W-1:0] GT_HET     = 2'd1;
    localparam logic [CODE_W-1:0] GT_MISSING = 2'd3;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Settle time after the last expected word, so that an indel or a site
    // with no result has surely drained.
    localparam int SETTLE_CYCLES   = 8;
    // Longest correct quiet stretch is the receiver hold-off below.
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASE_COUNT     = 5;
    localparam int SITES_PER_PHASE = 38;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic              new_scaffold;
        logic              is_indel;
        logic [POS_W-1:0]  position;
        logic [GENO_W-1:0] genotypes;
    } site_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] first_sample;
        logic [SAMPLE_W-1:0] second_sample;
        logic [POS_W-1:0]    tract_length;
        logic                long_tract;
        logic                last_of_site;
    } tract_t;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_COIN,
        RX_SPARSE,
        RX_PATTERN
    } rx_mode_t;

    logic clk;
    logic rst_n;

    pgtl_cfg_if    cfg_ch();
    pgtl_site_if   site_ch();
    pgtl_result_if result_ch();

    pairwise_genotype_tract_lengths dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .site   (site_ch),
        .result (result_ch)
    );

    // Predictor state: last incompatible position of every pair, plus the
    // threshold as last written.
    logic [POS_W-1:0] pair_last_pos [PAIR_SLOTS];
    logic [POS_W-1:0] tract_min_model;

    site_t  sites_to_send [$];
    tract_t pending_tracts [$];

    int mismatches   = 0;
    int results_seen = 0;
    int gap_left     = 0;
    int burst_left   = 0;
    int hold_left    = 0;
    int hold_stage   = 0;
    int mode_left    = 0;
    int idle_cycles  = 0;

    rx_mode_t         rx_mode = RX_STREAM;
    logic [7:0]       rx_pattern = 8'hFF;
    logic [POS_W-1:0] walk_pos = '0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Work out the result words of one accepted site and advance the pair
    // store. The last word of a site is held back so it can carry the flag.
    function automatic void score_site(input site_t s);
        logic [CODE_W-1:0] code [SAMPLE_COUNT];
        logic [POS_W-1:0]  prev;
        logic [POS_W-1:0]  len;
        tract_t            held;
        bit                have_held;
        int                slot;

        have_held = 1'b0;
        held      = '0;
        slot      = 0;
        // A new scaffold clears the store even on an indel.
        if (s.new_scaffold)
        begin
            for (int k = 0; k < PAIR_SLOTS; k++)
                pair_last_pos[k] = '0;
        end
        if (s.is_indel)
            return;
        for (int i = 0; i < SAMPLE_COUNT; i++)
            code[i] = s.genotypes[CODE_W*i +: CODE_W];
        for (int i = 0; i < SAMPLE_COUNT; i++)
        begin
            for (int j = i + 1; j < SAMPLE_COUNT; j++)
            begin
                if ((code[i] == GT_HOM_REF && code[j] == GT_HOM_ALT) ||
                    (code[i] == GT_HOM_ALT && code[j] == GT_HOM_REF))
                begin
                    if (have_held)
                        pending_tracts = {pending_tracts, held};
                    prev = pair_last_pos[slot];
                    // Position behind the stored one: saturate, but still store it.
                    len = (s.position >= prev) ? s.position - prev : '0;
                    held.first_sample  = SAMPLE_W'(i);
                    held.second_sample = SAMPLE_W'(j);
                    held.tract_length  = len;
                    held.long_tract    = (len >= tract_min_model);
                    held.last_of_site  = 1'b0;
                    have_held          = 1'b1;
                    pair_last_pos[slot] = s.position;
                end
                slot++;
            end
        end
        if (have_held)
        begin
            held.last_of_site = 1'b1;
            pending_tracts = {pending_tracts, held};
        end
    endfunction

    function automatic string tract_str(input tract_t t);
        return $sformatf("pair (%0d,%0d) length %0d long %0b last %0b",
                         t.first_sample, t.second_sample, t.tract_length,
                         t.long_tract, t.last_of_site);
    endfunction

    // Mostly hom ref / hom alt so pairs clash often; now and then a fully
    // random word so every code and bit shows up.
    function automatic logic [GENO_W-1:0] random_genotypes();
        logic [GENO_W-1:0] g;
        int                roll;

        g = '0;
        if ($urandom_range(0, 9) == 0)
            return GENO_W'($urandom_range(0, 16'hFFFF));
        for (int s = 0; s < SAMPLE_COUNT; s++)
        begin
            roll = $urandom_range(0, 9);
            g[CODE_W*s +: CODE_W] = (roll < 4) ? GT_HOM_REF :
                                    (roll < 8) ? GT_HOM_ALT :
                                    (roll == 8) ? GT_HET : GT_MISSING;
        end
        return g;
    endfunction

    // Sites walk forward along a scaffold, with scaffold changes, indels and
    // the odd jump anywhere in the coordinate range (which also walks back).
    function automatic site_t random_site();
        site_t s;
        int    roll;

        roll           = $urandom_range(0, 99);
        s.new_scaffold = (roll < 5);
        s.is_indel     = ($urandom_range(0, 99) < 8);
        if (s.new_scaffold)
            walk_pos = POS_W'($urandom_range(0, 2000));
        else if (roll < 12)
            walk_pos = POS_W'($urandom());
        else
            walk_pos = walk_pos + POS_W'($urandom_range(0, 4000));
        s.position  = walk_pos;
        s.genotypes = random_genotypes();
        return s;
    endfunction

    function automatic void queue_site(input logic new_scaffold, input logic is_indel,
                                       input logic [POS_W-1:0] position,
                                       input logic [GENO_W-1:0] genotypes);
        site_t s;

        s.new_scaffold = new_scaffold;
        s.is_indel     = is_indel;
        s.position     = position;
        s.genotypes    = genotypes;
        sites_to_send  = {sites_to_send, s};
    endfunction

    // Hold until every site is out and every expected word has come back,
    // then let the pipeline drain anything that yields no word.
    task automatic wait_idle();
        while (sites_to_send.size() != 0 || site_ch.valid || pending_tracts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tract_min(input logic [POS_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.long_tract_min <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid    <= 1'b0;
        tract_min_model = value;
    endtask

    // Sender: bursts of random length with random gaps; a word on the wire
    // stays put until it is taken.
    always @(posedge clk)
    begin : site_driver
        site_t next_site;
        logic  next_valid;

        if (!rst_n)
        begin
            site_ch.valid <= 1'b0;
        end
        else
        begin
            if (site_ch.valid && site_ch.ready)
            begin
                next_site.new_scaffold = site_ch.new_scaffold;
                next_site.is_indel     = site_ch.is_indel;
                next_site.position     = site_ch.position;
                next_site.genotypes    = site_ch.genotypes;
                score_site(next_site);
            end
            if (!site_ch.valid || site_ch.ready)
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (sites_to_send.size() > 0)
                begin
                    next_site = sites_to_send.pop_front();
                    site_ch.new_scaffold <= next_site.new_scaffold;
                    site_ch.is_indel     <= next_site.is_indel;
                    site_ch.position     <= next_site.position;
                    site_ch.genotypes    <= next_site.genotypes;
                    next_valid = 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                site_ch.valid <= next_valid;
            end
        end
    end

    // Receiver: pick a new stall mode whenever the current one runs out. Twice
    // in the run, hold off for a long stretch so the block backs up into its
    // input while the sender keeps offering sites.
    always @(posedge clk)
    begin : result_stall
        logic next_ready;

        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (hold_stage < 2 && results_seen >= (hold_stage == 0 ? 300 : 1200))
            begin
                hold_left = HOLD_CYCLES;
                hold_stage++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode    = rx_mode_t'($urandom_range(0, 3));
                    mode_left  = $urandom_range(20, 80);
                    rx_pattern = 8'($urandom_range(1, 255));
                end
                else
                begin
                    mode_left--;
                end
                case (rx_mode)
                    RX_STREAM:  next_ready = 1'b1;
                    RX_COIN:    next_ready = 1'($urandom_range(0, 1));
                    RX_SPARSE:  next_ready = ($urandom_range(0, 3) == 0);
                    default:    next_ready = rx_pattern[mode_left % 8];
                endcase
            end
            result_ch.ready <= next_ready;
        end
    end

    // Compare every accepted result word with the oldest expected one.
    always @(posedge clk)
    begin : result_check
        tract_t got;
        tract_t want;

        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.first_sample  = result_ch.first_sample;
            got.second_sample = result_ch.second_sample;
            got.tract_length  = result_ch.tract_length;
            got.long_tract    = result_ch.long_tract;
            got.last_of_site  = result_ch.last_of_site;
            results_seen++;
            if (pending_tracts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result word: %s", $realtime, tract_str(got));
            end
            else
            begin
                want = pending_tracts.pop_front();
                if (got.first_sample  !== want.first_sample  ||
                    got.second_sample !== want.second_sample ||
                    got.tract_length  !== want.tract_length  ||
                    got.long_tract    !== want.long_tract    ||
                    got.last_of_site  !== want.last_of_site)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: mismatch: expected %s, got %s",
                                 $realtime, tract_str(want), tract_str(got));
                end
            end
        end
    end

    // Drop the run if nothing moves on any channel for far longer than the
    // slowest correct run can stay quiet.
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((site_ch.valid && site_ch.ready) || (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t: no word moved for %0d cycles", $realtime, idle_cycles);
                    $display("FAIL pairwise_genotype_tract_lengths");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int               counted;
        site_t            s;
        logic [POS_W-1:0] threshold;

        rst_n                  = 1'b0;
        site_ch.valid          = 1'b0;
        site_ch.new_scaffold   = 1'b0;
        site_ch.is_indel       = 1'b0;
        site_ch.position       = '0;
        site_ch.genotypes      = '0;
        result_ch.ready        = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.long_tract_min  = '0;
        tract_min_model        = LONG_TRACT_MIN_RESET;
        for (int k = 0; k < PAIR_SLOTS; k++)
            pair_last_pos[k] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed sites under the reset threshold.
        // Uniform genotypes, all het, all missing: no pair clashes.
        queue_site(1'b0, 1'b0, 31'd100, 16'h0000);
        queue_site(1'b0, 1'b0, 31'd200, 16'hAAAA);
        queue_site(1'b0, 1'b0, 31'd300, 16'h5555);
        queue_site(1'b0, 1'b0, 31'd400, 16'hFFFF);
        // Pair (0,1) only, one short of the threshold, then exactly on it.
        queue_site(1'b0, 1'b0, 31'd9999, 16'hFFF8);
        queue_site(1'b0, 1'b0, 31'd19999, 16'hFFF2);
        // Position behind the stored one saturates; same position gives zero.
        queue_site(1'b0, 1'b0, 31'd5, 16'hFFF8);
        queue_site(1'b0, 1'b0, 31'd5, 16'hFFF8);
        // Alternating ref/alt: sixteen pairs at the top coordinate, then just
        // below it so every one saturates.
        queue_site(1'b0, 1'b0, POS_MAX, 16'h8888);
        queue_site(1'b0, 1'b0, POS_MAX - 31'd1, 16'h2222);
        // Indel with clashing genotypes: nothing out, nothing stored.
        queue_site(1'b0, 1'b1, 31'd50, 16'h8888);
        // Indel on a new scaffold still clears the store.
        queue_site(1'b1, 1'b1, 31'd60, 16'h8888);
        queue_site(1'b0, 1'b0, 31'd70, 16'h8888);
        // New scaffold at position zero, then the top coordinate.
        queue_site(1'b1, 1'b0, 31'd0, 16'h00AA);
        queue_site(1'b0, 1'b0, POS_MAX, 16'hAA00);
        // Ref and alt mixed with het and missing samples.
        queue_site(1'b0, 1'b0, 31'd1000, 16'h78D8);
        // Last pair only, then the first sample against the last one.
        queue_site(1'b0, 1'b0, 31'd2000, 16'h8555);
        queue_site(1'b0, 1'b0, 31'd3000, 16'h9554);
        wait_idle();

        // Random phases, each under its own threshold, extremes first.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       threshold = '0;
                1:       threshold = POS_MAX;
                2:       threshold = POS_W'($urandom_range(1, 3000));
                3:       threshold = POS_W'($urandom());
                default: threshold = POS_W'($urandom_range(3000, 20000));
            endcase
            write_tract_min(threshold);
            counted = 0;
            while (counted < SITES_PER_PHASE)
            begin
                s = random_site();
                sites_to_send = {sites_to_send, s};
                if (!s.is_indel)
                    counted++;
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("PASS pairwise_genotype_tract_lengths");
        else
            $display("FAIL pairwise_genotype_tract_lengths");
        $finish;
    end

endmodule
